// File: hdl/a2b_pkg.sv
// a2b_pkg: shared types, codes and prefix tables for the AVCC to Annex B converter.
// Used by a2b_front, a2b_cmd_queue, a2b_back and avcc_to_annexb_converter.
package a2b_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_AUD   = 2'd1;
    localparam logic [1:0] PFX_LONG  = 2'd2;
    localparam logic [1:0] PFX_SHORT = 2'd3;

    localparam logic [1:0] CLS_OTHER  = 2'd0;
    localparam logic [1:0] CLS_START  = 2'd1;
    localparam logic [1:0] CLS_CONFIG = 2'd2;
    localparam logic [1:0] CLS_VCL    = 2'd3;

    localparam logic [4:0] NAL_AUD = 5'd9;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    localparam logic [1:0] LEN_LAST_PHASE = 2'd3;

    typedef struct packed {
        logic [1:0] pfx;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    // start code, access unit delimiter and start code; the start codes are slices of it
    function automatic logic [7:0] aud_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd3, 4'd9: b = 8'h01;
            4'd4:       b = 8'h09;
            4'd5:       b = 8'hF0;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] pfx_len(input logic [1:0] pfx);
        logic [3:0] n;
        case (pfx)
            PFX_AUD:   n = 4'd10;
            PFX_LONG:  n = 4'd4;
            PFX_SHORT: n = 4'd3;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] pfx_start(input logic [1:0] pfx);
        return (pfx == PFX_SHORT) ? 4'd1 : 4'd0;
    endfunction

endpackage

// File: hdl/a2b_front.sv
// a2b_front: parses NAL lengths and types, tracks access units, issues byte commands.
// Depends on a2b_pkg.
module a2b_front
    import a2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        packet_first,
    input  logic        packet_last,
    input  logic [31:0] packet_time,
    input  logic        codec_is_h264,
    output logic        push,
    output cmd_t        cmd
);

    logic [31:0] last_time_reg, last_time_next;
    logic        time_seen_reg, time_seen_next;
    logic [1:0]  class_reg, class_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] left_reg, left_next;
    logic        skip_reg, skip_next;

    logic        new_au;
    logic [1:0]  class_e;
    logic [1:0]  phase_e;
    logic [31:0] accum_e;
    logic [31:0] left_e;
    logic        skip_e;
    logic        skip_v;
    logic [4:0]  nal_type;
    logic        is_cfg;
    logic [1:0]  new_cls;
    logic [1:0]  pfx;

    always_comb
    begin
        new_au   = !time_seen_reg || (packet_time != last_time_reg);
        class_e  = (packet_first && new_au) ? CLS_START : class_reg;
        phase_e  = packet_first ? 2'd0 : phase_reg;
        accum_e  = packet_first ? 32'd0 : accum_reg;
        left_e   = packet_first ? 32'd0 : left_reg;
        skip_e   = packet_first ? 1'b0 : skip_reg;
        nal_type = data_byte[4:0];
        is_cfg   = (nal_type == NAL_SPS) || (nal_type == NAL_PPS);
        new_cls  = (nal_type inside {[5'd1:5'd5]}) ? CLS_VCL : (is_cfg ? CLS_CONFIG : CLS_OTHER);

        last_time_next = last_time_reg;
        time_seen_next = time_seen_reg;
        class_next     = class_reg;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        left_next      = left_reg;
        skip_next      = skip_reg;
        skip_v         = skip_e;
        pfx            = PFX_NONE;
        push           = 1'b0;

        if (fire && codec_is_h264)
        begin
            if (packet_first)
            begin
                last_time_next = packet_time;
                time_seen_next = 1'b1;
            end
            class_next = class_e;
            phase_next = phase_e;
            accum_next = accum_e;
            left_next  = left_e;
            skip_next  = skip_e;

            if (left_e == 32'd0)
            begin
                accum_next = (phase_e == 2'd0) ? {24'd0, data_byte} : {accum_e[23:0], data_byte};
                if (phase_e == LEN_LAST_PHASE)
                begin
                    phase_next = 2'd0;
                    left_next  = accum_next;
                end
                else
                begin
                    phase_next = phase_e + 2'd1;
                end
            end
            else
            begin
                if (left_e == accum_e)
                begin
                    if (nal_type == NAL_AUD)
                    begin
                        skip_v     = 1'b1;
                        class_next = CLS_START;
                    end
                    else
                    begin
                        skip_v = 1'b0;
                        if (class_e == CLS_START || (class_e != CLS_OTHER && new_cls != class_e))
                            pfx = PFX_AUD;
                        else if (is_cfg)
                            pfx = PFX_LONG;
                        else
                            pfx = PFX_SHORT;
                        class_next = new_cls;
                    end
                end
                skip_next = skip_v;
                push      = !skip_v;
                left_next = left_e - 32'd1;
            end

            if (packet_last)
            begin
                phase_next = 2'd0;
                accum_next = 32'd0;
                left_next  = 32'd0;
                skip_next  = 1'b0;
            end
        end
    end

    assign cmd.pfx  = pfx;
    assign cmd.data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= 32'd0;
            time_seen_reg <= 1'b0;
            class_reg     <= CLS_START;
            phase_reg     <= 2'd0;
            accum_reg     <= 32'd0;
            left_reg      <= 32'd0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            last_time_reg <= last_time_next;
            time_seen_reg <= time_seen_next;
            class_reg     <= class_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            left_reg      <= left_next;
            skip_reg      <= skip_next;
        end
    end

endmodule

// File: hdl/a2b_cmd_queue.sv
// a2b_cmd_queue: small register FIFO of byte commands between front and back.
// Depends on a2b_pkg.
module a2b_cmd_queue
    import a2b_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        do_push     = push && (count_reg != QCNT_W'(QDEPTH));
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

// File: hdl/a2b_back.sv
// a2b_back: expands each command into its start code bytes plus the data byte.
// Depends on a2b_pkg; drives the registered output stage.
module a2b_back
    import a2b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data,
    output logic       out_last
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       load;
    logic [3:0] plen;
    logic       at_data;

    always_comb
    begin
        plen       = pfx_len(head.pfx);
        at_data    = (pos_reg == plen);
        load       = head_valid && (!valid_reg || out_ready);
        pop        = load && at_data;
        pos_next   = pos_reg;
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = at_data;
            data_next  = at_data ? head.data : aud_byte(pfx_start(head.pfx) + pos_reg);
            pos_next   = at_data ? 4'd0 : pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

// File: hdl/avcc_to_annexb_converter.sv
// avcc_to_annexb_converter: length-prefixed H.264 byte stream in, Annex B byte stream out.
// Path: front commands pass through the command queue into the registered output stage.
// Throughput: one input byte per cycle; one output byte per cycle while m_tready is high, so
// each NAL start adds 10, 4 or 3 prefix bytes; input stalls once the 4-entry queue fills.
// Reset: rst_n asynchronous, active low; clears parser, access unit state and queue.
// Depends on a2b_pkg, a2b_front, a2b_cmd_queue, a2b_back.
module avcc_to_annexb_converter
    import a2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] packet_time
    input  logic [1:0]  s_tuser,   // [0] packet_first, [1] codec_is_h264
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    logic    fire;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head;
    q_stat_t q_stat;

    assign s_tready = !q_stat.full;
    assign fire     = s_tvalid && s_tready;

    a2b_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .data_byte     (s_tdata[7:0]),
        .packet_first  (s_tuser[0]),
        .packet_last   (s_tlast),
        .packet_time   (s_tdata[39:8]),
        .codec_is_h264 (s_tuser[1]),
        .push          (push),
        .cmd           (push_cmd)
    );

    a2b_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    a2b_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_stat.empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("command queue count overflow");

    a_non_h264_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !s_tuser[1]) |=> (q_stat.count <= $past(q_stat.count)))
        else $error("non-H264 byte produced a command");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (q_stat.count == $past(q_stat.count) + QCNT_W'(1)))
        else $error("command push lost");
`endif

endmodule
